// ----- design/linear_interp_resampler_defines.svh -----
// Assertion macros used by the resampler top level.
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIR_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define LIR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- design/lir_pkg.sv -----
// Shared types and constants of the linear interpolation resampler.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

    localparam int DEF_TIME_BITS     = 48;
    localparam int DEF_FRACTION_BITS = 32;
    localparam int VALUE_BITS        = 64;
    localparam int CFG_BITS          = 32;

    localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 32'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_OUT
    } lir_state_t;

    typedef struct packed {
        logic valid;
        logic q_bit;
        logic last;
    } lir_digit_t;

endpackage

`default_nettype wire

// ----- design/lir_sample_if.sv -----
// Input channel carrying one timestamped sample word.
`timescale 1ns / 1ps
`default_nettype none

interface lir_sample_if #(
    parameter int TIME_BITS = lir_pkg::DEF_TIME_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic [TIME_BITS-1:0]                 sample_time;
    logic signed [lir_pkg::VALUE_BITS-1:0] sample_value;

    modport source (output valid, output sample_time, output sample_value, input ready);
    modport sink (input valid, input sample_time, input sample_value, output ready);
endinterface

`default_nettype wire

// ----- design/lir_point_if.sv -----
// Output channel carrying one resampled point word.
`timescale 1ns / 1ps
`default_nettype none

interface lir_point_if #(
    parameter int TIME_BITS = lir_pkg::DEF_TIME_BITS
);
    logic                                 valid;
    logic                                 ready;
    logic [TIME_BITS:0]                   out_time;
    logic signed [lir_pkg::VALUE_BITS-1:0] out_value;

    modport source (output valid, output out_time, output out_value, input ready);
    modport sink (input valid, input out_time, input out_value, output ready);
endinterface

`default_nettype wire

// ----- design/lir_divider.sv -----
// Restoring divider that emits one quotient bit per cycle, most significant first.
`timescale 1ns / 1ps
`default_nettype none

module lir_divider #(
    parameter int TIME_BITS     = lir_pkg::DEF_TIME_BITS,
    parameter int FRACTION_BITS = lir_pkg::DEF_FRACTION_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [TIME_BITS:0] num,
    input  wire logic [TIME_BITS-1:0] den,
    output lir_pkg::lir_digit_t     digit
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TIME_BITS:0]  rem_reg;
    logic [TIME_BITS:0]  rem_next;
    logic [TIME_BITS-1:0] den_reg;
    lir_pkg::lir_digit_t digit_reg;
    logic [TIME_BITS:0]  trial;
    logic                ge;
    logic                first;

    // The integer step takes the numerator as it is; a numerator at or above
    // the divisor is clamped to exactly one, which leaves no remainder.
    always_comb
    begin
        first = (cnt_reg == '0);
        trial = first ? rem_reg : {rem_reg[TIME_BITS-1:0], 1'b0};
        ge    = (trial >= {1'b0, den_reg});
        if (!ge)
        begin
            rem_next = trial;
        end
        else if (first)
        begin
            rem_next = '0;
        end
        else
        begin
            rem_next = trial - {1'b0, den_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            digit_reg <= '0;
        end
        else
        begin
            digit_reg.valid <= busy_reg;
            digit_reg.q_bit <= ge;
            digit_reg.last  <= (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign digit = digit_reg;

endmodule

`default_nettype wire

// ----- design/lir_mac.sv -----
// Shift-and-add multiplier fed one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lir_mac #(
    parameter int FRACTION_BITS = lir_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [lir_pkg::VALUE_BITS-1:0] mag,
    input  wire lir_pkg::lir_digit_t            digit,
    output logic [lir_pkg::VALUE_BITS-1:0]      off,
    output logic                                done
);

    localparam int VB    = lir_pkg::VALUE_BITS;
    localparam int ACC_W = VB + FRACTION_BITS + 1;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [VB-1:0]    mag_reg;
    logic             done_reg;

    always_comb
    begin
        acc_next = {acc_reg[ACC_W-2:0], 1'b0} + (digit.q_bit ? ACC_W'(mag_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            done_reg <= 1'b0;
        end
        else if (digit.valid && digit.last)
        begin
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mag_reg <= mag;
        end
        else if (digit.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign off  = acc_reg[FRACTION_BITS +: VB];
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- design/linear_interp_resampler.sv -----
// Top level of the linear interpolation resampler.
//
//   channel   direction  word
//   samples   in         sample_time, sample_value
//   points    out        out_time, out_value
//   cfg       in         cfg_wr_en, cfg_wr_data (interval_ms)
//
// A sample that emits nothing leaves the block idle and ready for the next;
// the first sample passes through the output state. An interpolated point
// passes through setup, run and output; in run the serial divider produces one ratio bit per cycle.
// Reset clears control state and sets interval_ms to 1000; there is no
// clearing pass. One finished word waits in the output register while the
// next sample is taken; a further result waits until that word leaves.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_interp_resampler_defines.svh"

module linear_interp_resampler #(
    parameter int TIME_BITS     = lir_pkg::DEF_TIME_BITS,
    parameter int FRACTION_BITS = lir_pkg::DEF_FRACTION_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lir_pkg::CFG_BITS-1:0] cfg_wr_data,
    lir_sample_if.sink                        samples,
    lir_point_if.source                       points
);

    localparam int VB    = lir_pkg::VALUE_BITS;
    localparam int TGT_W = TIME_BITS + 1;

    lir_pkg::lir_state_t state_reg;
    lir_pkg::lir_state_t state_next;

    logic                         started_reg;
    logic [lir_pkg::CFG_BITS-1:0] interval_reg;
    logic [TIME_BITS-1:0]         older_time_reg;
    logic [TIME_BITS-1:0]         newer_time_reg;
    logic signed [VB-1:0]         older_value_reg;
    logic signed [VB-1:0]         newer_value_reg;
    logic [TGT_W-1:0]             target_reg;
    logic [TGT_W-1:0]             res_time_reg;
    logic signed [VB-1:0]         res_value_reg;
    logic                         neg_reg;
    logic                         out_valid_reg;
    logic [TGT_W-1:0]             out_time_reg;
    logic signed [VB-1:0]         out_value_reg;

    logic                in_fire;
    logic                out_free;
    logic [TGT_W-1:0]    smp_time_ext;
    logic                reach;
    logic [TGT_W-1:0]    target_sum;
    logic [TIME_BITS-1:0] den;
    logic                degenerate;
    logic [TGT_W:0]      num_diff;
    logic [TGT_W-1:0]    num;
    logic                neg;
    logic [VB-1:0]       mag;
    logic [VB-1:0]       final_value;
    logic                calc_start;
    logic                load_out;
    logic [VB-1:0]       off;
    logic                mac_done;
    lir_pkg::lir_digit_t dig;

    assign in_fire        = samples.valid && samples.ready;
    assign samples.ready  = (state_reg == lir_pkg::ST_IDLE);
    assign out_free       = !out_valid_reg || points.ready;
    assign points.valid   = out_valid_reg;
    assign points.out_time  = out_time_reg;
    assign points.out_value = out_value_reg;

    always_comb
    begin
        smp_time_ext = {1'b0, samples.sample_time};
        reach        = (smp_time_ext >= target_reg);
        target_sum   = smp_time_ext + TGT_W'(interval_reg);

        den        = newer_time_reg - older_time_reg;
        degenerate = (newer_time_reg <= older_time_reg);
        num_diff   = {1'b0, res_time_reg} - {2'b00, older_time_reg};
        num        = num_diff[TGT_W] ? '0 : num_diff[TGT_W-1:0];
        neg        = (newer_value_reg < older_value_reg);
        if (degenerate)
        begin
            mag = '0;
        end
        else if (neg)
        begin
            mag = $unsigned(older_value_reg - newer_value_reg);
        end
        else
        begin
            mag = $unsigned(newer_value_reg - older_value_reg);
        end

        final_value = neg_reg ? ($unsigned(older_value_reg) - off)
                              : ($unsigned(older_value_reg) + off);
    end

    always_comb
    begin
        state_next = state_reg;
        calc_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!started_reg)
                    begin
                        state_next = lir_pkg::ST_OUT;
                    end
                    else if (reach)
                    begin
                        state_next = lir_pkg::ST_SETUP;
                    end
                end
            end
            lir_pkg::ST_SETUP:
            begin
                calc_start = 1'b1;
                state_next = lir_pkg::ST_RUN;
            end
            lir_pkg::ST_RUN:
            begin
                if (mac_done)
                begin
                    state_next = lir_pkg::ST_OUT;
                end
            end
            lir_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = lir_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lir_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            interval_reg  <= lir_pkg::INTERVAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                started_reg <= 1'b1;
            end
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (points.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            newer_time_reg  <= samples.sample_time;
            newer_value_reg <= samples.sample_value;
            older_time_reg  <= started_reg ? newer_time_reg : samples.sample_time;
            older_value_reg <= started_reg ? newer_value_reg : samples.sample_value;
            res_time_reg    <= started_reg ? target_reg : smp_time_ext;
            res_value_reg   <= samples.sample_value;
            if (!started_reg || reach)
            begin
                target_reg <= target_sum;
            end
        end
        if (state_reg == lir_pkg::ST_SETUP)
        begin
            neg_reg <= neg;
        end
        if ((state_reg == lir_pkg::ST_RUN) && mac_done)
        begin
            res_value_reg <= $signed(final_value);
        end
        if (load_out)
        begin
            out_time_reg  <= res_time_reg;
            out_value_reg <= res_value_reg;
        end
    end

    lir_divider #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .num   (num),
        .den   (den),
        .digit (dig)
    );

    lir_mac #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .mag   (mag),
        .digit (dig),
        .off   (off),
        .done  (mac_done)
    );

    `LIR_ASSERT_IMPLIES(a_digit_in_run, clk, rst_n, dig.valid, state_reg == lir_pkg::ST_RUN)
    `LIR_ASSERT_NEXT(a_quiet_sample, clk, rst_n, in_fire && started_reg && !reach, state_reg == lir_pkg::ST_IDLE)
    `LIR_ASSERT_NEXT(a_value_between, clk, rst_n, (state_reg == lir_pkg::ST_RUN) && mac_done, ((res_value_reg >= older_value_reg) && (res_value_reg <= newer_value_reg)) || ((res_value_reg <= older_value_reg) && (res_value_reg >= newer_value_reg)))

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the linear interpolation resampler with a point scoreboard.
`timescale 1ns / 1ps

module testbench;

    localparam int TIME_W = lir_pkg::DEF_TIME_BITS;
    localparam int FRAC_W = lir_pkg::DEF_FRACTION_BITS;
    localparam int VAL_W = lir_pkg::VALUE_BITS;
    localparam int CFG_W = lir_pkg::CFG_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 14;
    localparam int PHASE_ITEMS = 130;
    localparam int HOLD_CYCLES = 700;
    localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [CFG_W-1:0] IVAL_MAX = '1;

    typedef struct packed {
        logic [TIME_W:0] stamp;
        logic [VAL_W-1:0] value;
    } point_t;

    class point_scoreboard;
        point_t want_q[$];
        int mismatches;
        bit started;
        logic [TIME_W-1:0] older_time;
        logic [TIME_W-1:0] newer_time;
        logic [VAL_W-1:0] older_value;
        logic [VAL_W-1:0] newer_value;
        logic [TIME_W:0] target_time;
        logic [CFG_W-1:0] interval_ms;

        function new();
            mismatches = 0;
            started = 1'b0;
            older_time = '0;
            newer_time = '0;
            older_value = '0;
            newer_value = '0;
            target_time = '0;
            interval_ms = lir_pkg::INTERVAL_RESET;
        endfunction

        function void set_interval(logic [CFG_W-1:0] v);
            interval_ms = v;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function logic [VAL_W-1:0] value_at(logic [TIME_W:0] at);
            logic [TIME_W-1:0] span;
            logic [TIME_W:0] num;
            logic [TIME_W+1:0] rem;
            logic [FRAC_W:0] ratio;
            logic [VAL_W-1:0] mag;
            logic [2*VAL_W-1:0] prod;
            logic down;
            if (newer_time <= older_time)
                return older_value;
            span = newer_time - older_time;
            num = (at > older_time) ? at - older_time : '0;
            if (num > span)
                num = span;
            ratio = (num >= span) ? 1 : 0;
            rem = ratio[0] ? num - span : num;
            for (int i = 0; i < FRAC_W; i++)
            begin
                rem = rem << 1;
                ratio = ratio << 1;
                if (rem >= span)
                begin
                    rem = rem - span;
                    ratio[0] = 1'b1;
                end
            end
            down = $signed(newer_value) < $signed(older_value);
            mag = down ? older_value - newer_value : newer_value - older_value;
            prod = mag * ratio;
            return down ? older_value - prod[FRAC_W +: VAL_W]
                        : older_value + prod[FRAC_W +: VAL_W];
        endfunction

        function void note_sample(logic [TIME_W-1:0] t, logic [VAL_W-1:0] v);
            point_t p;
            if (!started)
            begin
                started = 1'b1;
                older_time = t;
                newer_time = t;
                older_value = v;
                newer_value = v;
                target_time = {1'b0, t} + interval_ms;
                p.stamp = {1'b0, t};
                p.value = v;
                want_q.insert(want_q.size(), p);
                return;
            end
            older_time = newer_time;
            older_value = newer_value;
            newer_time = t;
            newer_value = v;
            if ({1'b0, newer_time} < target_time)
                return;
            p.stamp = target_time;
            p.value = value_at(target_time);
            want_q.insert(want_q.size(), p);
            target_time = {1'b0, t} + interval_ms;
        endfunction

        task report(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
            if (mismatches < 40)
                $display("%0t point %0s: got %h, expected %h", $time, field, got, want);
            mismatches++;
        endtask

        task check_point(logic [TIME_W:0] stamp, logic [VAL_W-1:0] value);
            point_t p;
            if (want_q.size() == 0)
            begin
                report("unexpected word", value, '0);
                return;
            end
            p = want_q.pop_front();
            if (stamp !== p.stamp)
                report("out_time", stamp, p.stamp);
            if (value !== p.value)
                report("out_value", value, p.value);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    lir_sample_if samples_ch();
    lir_point_if points_ch();

    point_scoreboard sb;
    logic [TIME_W-1:0] now_ms = '0;
    logic [VAL_W-1:0] last_value = '0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;
    int take_hold = 0;
    int cycle_count = 0;

    linear_interp_resampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .samples(samples_ch),
        .points(points_ch)
    );

    always #4 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("linear_interp_resampler: mismatch");
        $finish;
    end

    function automatic logic [63:0] wide_rand();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return VMIN;
                    1: return VMAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1: return last_value + $urandom_range(0, 2000) - 1000;
            default: return wide_rand();
        endcase
    endfunction

    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] v);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.sample_time <= t;
        samples_ch.sample_value <= v;
        do @(posedge clk); while (!samples_ch.ready);
        sb.note_sample(t, v);
        if (t > now_ms)
            now_ms = t;
        last_value = v;
    endtask

    task automatic settle();
        samples_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (FRAC_W + 16) @(posedge clk);
    endtask

    task automatic write_interval(input logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_interval(v);
    endtask

    task automatic run_phase(input int count, input logic [CFG_W-1:0] ival);
        logic [63:0] span;
        logic [63:0] t;
        span = (ival < 64) ? 64 : ival;
        repeat (count)
        begin
            case ($urandom_range(0, 11))
                0: t = now_ms;
                1:
                begin
                    t = wide_rand() % (span + 1);
                    t = (t > now_ms) ? '0 : now_ms - t;
                end
                2: t = now_ms + wide_rand() % (4 * span + 1);
                default: t = now_ms + wide_rand() % (2 * span + 1);
            endcase
            send_sample(t[TIME_W-1:0], pick_value());
        end
    endtask

    initial
    begin : point_taker
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = take_steady ? 0 : $urandom_range(0, 17);
            if (take_hold > 0)
            begin
                gap = take_hold;
                take_hold = 0;
            end
            if (gap > 0)
            begin
                points_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            points_ch.ready <= 1'b1;
            do @(posedge clk); while (!(points_ch.valid && points_ch.ready));
            sb.check_point(points_ch.out_time, points_ch.out_value);
        end
    end

    initial
    begin
        logic [CFG_W-1:0] ival;
        logic [63:0] base;
        sb = new();
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        samples_ch.valid <= 1'b0;
        samples_ch.sample_time <= '0;
        samples_ch.sample_value <= '0;
        points_ch.ready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset interval: first word passes through, then whole-range slopes.
        send_sample(48'd0, VMAX);
        send_sample(48'd500, VMIN);
        send_sample(48'd1000, VMIN);
        send_sample(48'd1000, VMAX);
        send_sample(48'd2000, '0);
        send_sample(48'd5000, '1);
        send_sample(48'd4000, 64'd5);
        send_sample(48'd6000, VMIN);
        send_sample(48'd7000, VMAX);
        send_sample(48'd8500, VMAX);
        send_sample(48'd9999, VMIN);
        send_sample(48'd10000, VMIN);
        send_sample(48'd11500, VMAX);

        // Zero interval: equal point times give the older value.
        settle();
        write_interval('0);
        send_sample(48'd20000, pick_value());
        send_sample(48'd20000, pick_value());
        send_sample(48'd20003, pick_value());

        // Largest interval with a tiny interpolation ratio.
        settle();
        write_interval(IVAL_MAX);
        send_sample(48'd30000, pick_value());
        send_sample(48'd30000 + IVAL_MAX - 1, pick_value());
        send_sample(48'd30000 + IVAL_MAX + 48'h2_0000_0000, pick_value());

        for (int k = 0; k < PHASES; k++)
        begin
            settle();
            case (k % 7)
                0: ival = 1;
                1: ival = $urandom_range(100, 5000);
                2: ival = '0;
                3: ival = IVAL_MAX;
                4: ival = $urandom;
                5: ival = 1000;
                default: ival = $urandom_range(1, 40);
            endcase
            write_interval(ival);
            send_steady = (k % 4 == 1);
            take_steady = (k % 5 == 2);
            if (k % 7 == 3)
            begin
                take_hold = HOLD_CYCLES;
                send_steady = 1'b1;
            end
            base = (64'd1 << (TIME_W - 4)) * k + wide_rand() % (64'd1 << 40);
            if (base > now_ms)
                now_ms = base[TIME_W-1:0];
            run_phase(PHASE_ITEMS, ival);
        end

        // Top of the time range last, since no later target can lie below it.
        settle();
        send_steady = 1'b0;
        take_steady = 1'b0;
        write_interval('0);
        send_sample('1, pick_value());
        send_sample('1, pick_value());
        send_sample('1, pick_value());
        settle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("linear_interp_resampler: match");
        else
            $display("linear_interp_resampler: mismatch");
        $finish;
    end

endmodule

// ----- linear_interp_resampler.f -----
+incdir+design
design/lir_pkg.sv
design/lir_sample_if.sv
design/lir_point_if.sv
design/lir_divider.sv
design/lir_mac.sv
design/linear_interp_resampler.sv
tb/sv/testbench.sv
